@@ rtl/falt_pkg.sv @@
// Shared types and constants for the failed-attempt lockout table.
package falt_pkg;

  localparam int unsigned ADDR_W            = 32;
  localparam int unsigned COUNT_W           = 8;
  localparam int unsigned CFG_W             = 16;
  localparam int unsigned OP_W              = 3;
  localparam int unsigned STATUS_W          = 2;
  localparam int unsigned CFG_ADDR_W        = 1;
  localparam int unsigned TABLE_ENTRIES_DEF = 64;
  localparam int unsigned TIME_BITS_DEF     = 32;

  localparam logic [COUNT_W-1:0] MAX_FAIL_RST   = 8'd3;
  localparam logic [CFG_W-1:0]   LOCK_TICKS_RST = 16'd5;
  localparam logic [COUNT_W-1:0] COUNT_SAT      = 8'hFF;

  typedef enum logic [OP_W-1:0] {
    OP_CHECK   = 3'd0,
    OP_SUCCESS = 3'd1,
    OP_FAILURE = 3'd2,
    OP_CLEAR   = 3'd3,
    OP_TICK    = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_LOCKED     = 2'd1,
    ST_NOT_WHITE  = 2'd2,
    ST_TABLE_FULL = 2'd3
  } status_e;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_MAX_FAILURES  = 1'b0,
    REG_LOCKOUT_TICKS = 1'b1
  } reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_UPDATE,
    S_RESP
  } state_e;

endpackage

@@ rtl/failed_attempt_lockout_table_core.sv @@
// Top level of the failed-attempt lockout table: sequencer, table memory and result logic.

// A request is taken when start_i is high and busy_o is low. Check, success, failure and
// clear requests walk the whole table through its single read port, one entry per cycle,
// and then pass through a drain state before the result state; a failure also passes
// through an update state after the drain, to write the entry back. A tick or an unused
// op code answers in the cycle after the request. Each result is shown for one cycle
// with result_valid_o high and cannot be held off; busy_o stays high until that cycle
// has passed. Configuration writes are taken at any edge but are meant to be made while
// the block is idle.
module failed_attempt_lockout_table_core #(
  parameter int unsigned TABLE_ENTRIES = falt_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned TIME_BITS     = falt_pkg::TIME_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [falt_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [falt_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [falt_pkg::OP_W-1:0]       op_i,
  input  logic [falt_pkg::ADDR_W-1:0]     ip_address_i,
  input  logic                           whitelisted_i,
  output logic                           result_valid_o,
  output logic                           allowed_o,
  output logic [falt_pkg::STATUS_W-1:0]   status_o,
  output logic [falt_pkg::COUNT_W-1:0]    fail_count_o,
  output logic                           locked_out_o
);
  import falt_pkg::*;

  localparam int unsigned IdxW = $clog2(TABLE_ENTRIES);
  localparam int unsigned EntW = ADDR_W + COUNT_W + TIME_BITS;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_ENTRIES - 1);
  localparam logic [TIME_BITS-1:0] TimeMax = {TIME_BITS{1'b1}};

  state_e state_q, state_d;

  logic [OP_W-1:0]      op_q, op_d;
  logic [ADDR_W-1:0]    ip_q, ip_d;
  logic                 wl_q, wl_d;
  logic [IdxW-1:0]      rd_idx_q, rd_idx_d;
  logic [IdxW-1:0]      chk_idx_q, chk_idx_d;
  logic                 chk_vld_q, chk_vld_d;
  logic                 found_q, found_d;
  logic                 full_q, full_d;
  logic [IdxW-1:0]      m_idx_q, m_idx_d;
  logic [COUNT_W-1:0]   m_fail_q, m_fail_d;
  logic [TIME_BITS-1:0] m_dl_q, m_dl_d;
  logic                 free_found_q, free_found_d;
  logic [IdxW-1:0]      free_idx_q, free_idx_d;
  logic [TIME_BITS-1:0] now_q, now_d;
  logic [COUNT_W-1:0]   max_fail_q, max_fail_d;
  logic [CFG_W-1:0]     lock_ticks_q, lock_ticks_d;
  logic [TABLE_ENTRIES-1:0] valid_q, valid_d;

  logic [EntW-1:0] mem_q [TABLE_ENTRIES];
  logic [EntW-1:0] rdata_q;
  logic            mem_we;
  logic [IdxW-1:0] mem_widx;
  logic [EntW-1:0] mem_wdata;

  logic [ADDR_W-1:0]    rd_addr;
  logic [COUNT_W-1:0]   rd_fail;
  logic [TIME_BITS-1:0] rd_dl;
  logic                 ent_valid;
  logic                 ent_match;
  logic                 ent_expired;

  logic [IdxW-1:0]      upd_idx;
  logic [COUNT_W-1:0]   upd_fail;
  logic [TIME_BITS-1:0] upd_dl;
  logic [COUNT_W-1:0]   new_fail;
  logic [TIME_BITS:0]   dl_sum;
  logic [TIME_BITS-1:0] dl_sat;
  logic                 res_locked;

  assign rd_addr     = rdata_q[EntW-1 -: ADDR_W];
  assign rd_fail     = rdata_q[TIME_BITS +: COUNT_W];
  assign rd_dl       = rdata_q[TIME_BITS-1:0];
  assign ent_valid   = valid_q[chk_idx_q];
  assign ent_match   = ent_valid && (rd_addr == ip_q);
  assign ent_expired = ent_valid && (rd_fail >= max_fail_q) && !(now_q < rd_dl);

  assign new_fail = (upd_fail == COUNT_SAT) ? COUNT_SAT : upd_fail + COUNT_W'(1);
  assign dl_sum   = {1'b0, now_q} + {{(TIME_BITS + 1 - CFG_W){1'b0}}, lock_ticks_q};
  assign dl_sat   = dl_sum[TIME_BITS] ? TimeMax : dl_sum[TIME_BITS-1:0];
  assign res_locked = found_q && (now_q < m_dl_q);

  always_comb begin
    upd_idx  = free_idx_q;
    upd_fail = '0;
    upd_dl   = '0;
    if (found_q) begin
      upd_idx  = m_idx_q;
      upd_fail = m_fail_q;
      upd_dl   = m_dl_q;
    end
  end

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    ip_d         = ip_q;
    wl_d         = wl_q;
    rd_idx_d     = rd_idx_q;
    chk_idx_d    = chk_idx_q;
    chk_vld_d    = 1'b0;
    found_d      = found_q;
    full_d       = full_q;
    m_idx_d      = m_idx_q;
    m_fail_d     = m_fail_q;
    m_dl_d       = m_dl_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    now_d        = now_q;
    max_fail_d   = max_fail_q;
    lock_ticks_d = lock_ticks_q;
    valid_d      = valid_q;
    mem_we       = 1'b0;
    mem_widx     = upd_idx;
    mem_wdata    = {ip_q, new_fail, upd_dl};

    busy_o         = (state_q != S_IDLE);
    result_valid_o = 1'b0;
    allowed_o      = 1'b0;
    status_o       = ST_OK;
    fail_count_o   = '0;
    locked_out_o   = 1'b0;

    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_MAX_FAILURES:  max_fail_d   = cfg_wdata_i[COUNT_W-1:0];
        REG_LOCKOUT_TICKS: lock_ticks_d = cfg_wdata_i;
        default: ;
      endcase
    end

    if (chk_vld_q) begin
      if (op_q == OP_CHECK) begin
        if (ent_expired) begin
          valid_d[chk_idx_q] = 1'b0;
        end else if (ent_match) begin
          found_d  = 1'b1;
          m_fail_d = rd_fail;
          m_dl_d   = rd_dl;
        end
      end else if (op_q == OP_SUCCESS || op_q == OP_CLEAR) begin
        if (ent_match) begin
          valid_d[chk_idx_q] = 1'b0;
        end
      end else begin
        if (ent_match) begin
          found_d  = 1'b1;
          m_idx_d  = chk_idx_q;
          m_fail_d = rd_fail;
          m_dl_d   = rd_dl;
        end
        if (!ent_valid && !free_found_q) begin
          free_found_d = 1'b1;
          free_idx_d   = chk_idx_q;
        end
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_d         = op_i;
          ip_d         = ip_address_i;
          wl_d         = whitelisted_i;
          rd_idx_d     = '0;
          found_d      = 1'b0;
          full_d       = 1'b0;
          free_found_d = 1'b0;
          state_d      = S_RESP;
          if (op_i == OP_CHECK || op_i == OP_SUCCESS || op_i == OP_FAILURE ||
              op_i == OP_CLEAR) begin
            state_d = S_SCAN;
          end else if (op_i == OP_TICK && now_q != TimeMax) begin
            now_d = now_q + TIME_BITS'(1);
          end
        end
      end
      S_SCAN: begin
        chk_vld_d = 1'b1;
        chk_idx_d = rd_idx_q;
        rd_idx_d  = rd_idx_q + IdxW'(1);
        if (rd_idx_q == LastIdx) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = (op_q == OP_FAILURE) ? S_UPDATE : S_RESP;
      end
      S_UPDATE: begin
        state_d = S_RESP;
        if (found_q || free_found_q) begin
          mem_we   = 1'b1;
          found_d  = 1'b1;
          m_idx_d  = upd_idx;
          m_fail_d = new_fail;
          m_dl_d   = (new_fail >= max_fail_q) ? dl_sat : upd_dl;
          mem_wdata = {ip_q, new_fail, m_dl_d};
          valid_d[upd_idx] = 1'b1;
        end else begin
          full_d = 1'b1;
        end
      end
      S_RESP: begin
        result_valid_o = 1'b1;
        state_d        = S_IDLE;
        if (op_q == OP_CHECK) begin
          fail_count_o = found_q ? m_fail_q : '0;
          locked_out_o = res_locked;
          if (res_locked) begin
            status_o = ST_LOCKED;
          end else if (!wl_q) begin
            status_o = ST_NOT_WHITE;
          end else begin
            allowed_o = 1'b1;
          end
        end else if (op_q == OP_FAILURE) begin
          if (full_q) begin
            status_o = ST_TABLE_FULL;
          end else begin
            fail_count_o = m_fail_q;
            locked_out_o = res_locked;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      chk_vld_q    <= 1'b0;
      found_q      <= 1'b0;
      full_q       <= 1'b0;
      free_found_q <= 1'b0;
      now_q        <= '0;
      max_fail_q   <= MAX_FAIL_RST;
      lock_ticks_q <= LOCK_TICKS_RST;
      valid_q      <= '0;
    end else begin
      state_q      <= state_d;
      chk_vld_q    <= chk_vld_d;
      found_q      <= found_d;
      full_q       <= full_d;
      free_found_q <= free_found_d;
      now_q        <= now_d;
      max_fail_q   <= max_fail_d;
      lock_ticks_q <= lock_ticks_d;
      valid_q      <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    ip_q       <= ip_d;
    wl_q       <= wl_d;
    rd_idx_q   <= rd_idx_d;
    chk_idx_q  <= chk_idx_d;
    m_idx_q    <= m_idx_d;
    m_fail_q   <= m_fail_d;
    m_dl_q     <= m_dl_d;
    free_idx_q <= free_idx_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_widx] <= mem_wdata;
    end
    rdata_q <= mem_q[rd_idx_q];
  end

endmodule
